### rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked assertion helpers; empty when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define VCA_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");
`define VCA_ASSERT_NEVER(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("forbidden condition seen");
`else
`define VCA_ASSERT(lbl, clk, rst_n, prop)
`define VCA_ASSERT_NEVER(lbl, clk, rst_n, expr)
`endif
`endif

### rtl/vca_pkg.sv
// ----------------------------------------------------------------------------
// Vigenere custom alphabet package
// Shared types, constants and width helpers.
// ----------------------------------------------------------------------------
package vca_pkg;

    localparam int ALPHA_MAX_DEF = 128;
    localparam int KEY_MAX_DEF   = 256;
    localparam int SYM_W         = 8;
    localparam int POS_W         = 8;
    localparam int ASIZE_W       = 8;
    localparam int KLEN_W        = 9;
    localparam int CFG_W         = 9;
    localparam int CMD_W         = 2;
    localparam int ALPHA_MIN     = 2;
    localparam int QDEPTH        = 2;

    typedef enum logic [CMD_W-1:0] {
        CMD_LOAD_ALPHA = 2'd0,
        CMD_LOAD_KEY   = 2'd1,
        CMD_ENCRYPT    = 2'd2,
        CMD_DECRYPT    = 2'd3
    } t_cmd;

    typedef enum logic {
        CFG_ALPHA_SIZE = 1'b0,
        CFG_KEY_LEN    = 1'b1
    } t_cfg_idx;

    typedef struct packed {
        logic valid;
        logic full;
    } t_q_status;

    typedef struct packed {
        logic busy;
        logic crypt;
    } t_back_status;

    function automatic int clog2_min1(input int v);
        return (v > 1) ? $clog2(v) : 1;
    endfunction

    function automatic int q_addr_w(input int alpha_max, input int key_max);
        int a;
        int k;
        a = clog2_min1(alpha_max);
        k = clog2_min1(key_max);
        return (a > k) ? a : k;
    endfunction

    function automatic int q_entry_w(input int alpha_max, input int key_max);
        return CMD_W + q_addr_w(alpha_max, key_max) + SYM_W;
    endfunction

endpackage

### rtl/vca_front.sv
// ----------------------------------------------------------------------------
// Front end
// Accepts words, drops out-of-range loads, tags each crypt word with its
// key position.
// ----------------------------------------------------------------------------
module vca_front #(
    parameter int ALPHA_MAX = vca_pkg::ALPHA_MAX_DEF,
    parameter int KEY_MAX   = vca_pkg::KEY_MAX_DEF
) (
    input  logic                                          i_clk,
    input  logic                                          i_rst_n,
    input  logic                                          i_valid,
    output logic                                          o_ready,
    input  vca_pkg::t_cmd                                 i_cmd,
    input  logic [vca_pkg::POS_W-1:0]                     i_position,
    input  logic [vca_pkg::SYM_W-1:0]                     i_symbol,
    input  logic                                          i_som,
    input  logic [vca_pkg::KLEN_W-1:0]                    i_klen,
    output logic                                          o_push_valid,
    input  logic                                          i_push_ready,
    output logic [vca_pkg::q_entry_w(ALPHA_MAX, KEY_MAX)-1:0] o_push_data
);
    import vca_pkg::*;

    localparam int KW = clog2_min1(KEY_MAX);
    localparam int QA = q_addr_w(ALPHA_MAX, KEY_MAX);
    localparam int CW = ((KW > KLEN_W) ? KW : KLEN_W) + 1;

    logic [KW-1:0] r_kp;
    logic [KW-1:0] n_kp;
    logic [KW-1:0] kp_use;
    logic [CW-1:0] kp_inc;
    logic [CW-1:0] klen_ext;
    logic [QA-1:0] addr;
    logic          crypt;
    logic          keep;

    always_comb begin
        crypt    = i_cmd inside {CMD_ENCRYPT, CMD_DECRYPT};
        klen_ext = CW'(i_klen);
        kp_use   = (i_som || (CW'(r_kp) >= klen_ext)) ? '0 : r_kp;
        kp_inc   = CW'(kp_use) + CW'(1);
        n_kp     = (kp_inc >= klen_ext) ? '0 : kp_inc[KW-1:0];
        case (i_cmd)
            CMD_LOAD_ALPHA: keep = (int'(i_position) < ALPHA_MAX);
            CMD_LOAD_KEY:   keep = (int'(i_position) < KEY_MAX);
            default:        keep = 1'b1;
        endcase
        addr = crypt ? QA'(kp_use) : QA'(i_position);
    end

    assign o_ready      = i_push_ready;
    assign o_push_valid = i_valid && keep;
    assign o_push_data  = {i_cmd, addr, i_symbol};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kp <= '0;
        end else if (i_valid && o_ready && crypt) begin
            r_kp <= n_kp;
        end
    end

endmodule

### rtl/vca_fifo.sv
// ----------------------------------------------------------------------------
// Command queue
// Short word queue between front and back end.
// ----------------------------------------------------------------------------
module vca_fifo #(
    parameter int W = 18
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push_valid,
    output logic               o_push_ready,
    input  logic [W-1:0]       i_push_data,
    output logic               o_pop_valid,
    input  logic               i_pop_ready,
    output logic [W-1:0]       o_pop_data,
    output vca_pkg::t_q_status o_status
);
    import vca_pkg::*;

    localparam int PW = clog2_min1(QDEPTH);
    localparam int NW = $clog2(QDEPTH + 1);

    logic [W-1:0]  r_mem [QDEPTH];
    logic [PW-1:0] r_wp;
    logic [PW-1:0] r_rp;
    logic [NW-1:0] r_cnt;
    logic          push;
    logic          pop;

    assign o_push_ready    = (r_cnt != NW'(QDEPTH));
    assign o_pop_valid     = (r_cnt != '0);
    assign o_pop_data      = r_mem[r_rp];
    assign push            = i_push_valid && o_push_ready;
    assign pop             = o_pop_valid && i_pop_ready;
    assign o_status.valid  = o_pop_valid;
    assign o_status.full   = !o_push_ready;

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wp] <= i_push_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wp <= (r_wp == PW'(QDEPTH - 1)) ? '0 : r_wp + PW'(1);
            end
            if (pop) begin
                r_rp <= (r_rp == PW'(QDEPTH - 1)) ? '0 : r_rp + PW'(1);
            end
            case ({push, pop})
                2'b10:   r_cnt <= r_cnt + NW'(1);
                2'b01:   r_cnt <= r_cnt - NW'(1);
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

### rtl/vca_back.sv
// ----------------------------------------------------------------------------
// Back end
// Runs loads and crypt words: table lookups, bit-serial mod n, add or
// subtract mod n, symbol lookup, output register.
// ----------------------------------------------------------------------------
module vca_back #(
    parameter int ALPHA_MAX = vca_pkg::ALPHA_MAX_DEF,
    parameter int KEY_MAX   = vca_pkg::KEY_MAX_DEF
) (
    input  logic                                          i_clk,
    input  logic                                          i_rst_n,
    input  logic                                          i_pop_valid,
    output logic                                          o_pop_ready,
    input  logic [vca_pkg::q_entry_w(ALPHA_MAX, KEY_MAX)-1:0] i_pop_data,
    input  logic [$clog2(ALPHA_MAX+1)-1:0]                i_n,
    output logic                                          o_out_valid,
    input  logic                                          i_out_ready,
    output logic [vca_pkg::SYM_W-1:0]                     o_out_symbol,
    output vca_pkg::t_back_status                         o_status
);
    import vca_pkg::*;

    localparam int AW  = clog2_min1(ALPHA_MAX);
    localparam int KW  = clog2_min1(KEY_MAX);
    localparam int QA  = q_addr_w(ALPHA_MAX, KEY_MAX);
    localparam int EW  = q_entry_w(ALPHA_MAX, KEY_MAX);
    localparam int RW  = AW + 1;
    localparam int CNW = $clog2(AW + 1);
    localparam int MAPD = 1 << SYM_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_KEY,
        S_MAP,
        S_RED,
        S_SUM,
        S_OUT
    } t_state;

    t_state           r_state;
    t_cmd             op;
    logic [QA-1:0]    addr;
    logic [SYM_W-1:0] sym;
    logic             fire;
    logic             map_we;
    logic             key_we;
    logic             out_load;
    logic [SYM_W-1:0] map_ra;
    logic [AW-1:0]    i2s_ra;

    logic [AW-1:0]    r_map [MAPD];
    logic [MAPD-1:0]  r_map_vld;
    logic [AW-1:0]    r_map_q;
    logic             r_map_hit;
    logic [SYM_W-1:0] r_i2s [ALPHA_MAX];
    logic [SYM_W-1:0] r_i2s_q;
    logic [SYM_W-1:0] r_keys [KEY_MAX];
    logic [SYM_W-1:0] r_key_q;

    logic             r_enc;
    logic [AW-1:0]    r_ma;
    logic [AW-1:0]    r_ka;
    logic [RW-1:0]    r_mr;
    logic [RW-1:0]    r_kr;
    logic [CNW-1:0]   r_cnt;
    logic             r_out_valid;
    logic [SYM_W-1:0] r_out_sym;

    logic [RW-1:0]    n_ext;
    logic [RW-1:0]    mt;
    logic [RW-1:0]    kt;
    logic [RW-1:0]    n_mr;
    logic [RW-1:0]    n_kr;
    logic [RW-1:0]    sum;
    logic [RW-1:0]    res;

    assign op   = t_cmd'(i_pop_data[EW-1 -: CMD_W]);
    assign addr = i_pop_data[SYM_W +: QA];
    assign sym  = i_pop_data[SYM_W-1:0];

    assign o_pop_ready = (r_state == S_IDLE);
    assign fire        = i_pop_valid && o_pop_ready;
    assign map_we      = fire && (op == CMD_LOAD_ALPHA);
    assign key_we      = fire && (op == CMD_LOAD_KEY);
    assign map_ra      = (r_state == S_IDLE) ? sym : r_key_q;
    assign out_load    = (r_state == S_OUT) && (!r_out_valid || i_out_ready);

    always_comb begin
        n_ext = RW'(i_n);
        mt    = {r_mr[AW-1:0], r_ma[AW-1]};
        kt    = {r_kr[AW-1:0], r_ka[AW-1]};
        n_mr  = (mt >= n_ext) ? mt - n_ext : mt;
        n_kr  = (kt >= n_ext) ? kt - n_ext : kt;
        sum   = r_mr + r_kr;
        if (r_enc) begin
            res = (sum >= n_ext) ? sum - n_ext : sum;
        end else begin
            res = (r_mr >= r_kr) ? r_mr - r_kr : r_mr + n_ext - r_kr;
        end
        i2s_ra = res[AW-1:0];
    end

    // tables
    always_ff @(posedge i_clk) begin
        if (map_we) begin
            r_map[sym] <= addr[AW-1:0];
        end
        r_map_q <= r_map[map_ra];
    end

    always_ff @(posedge i_clk) begin
        if (map_we) begin
            r_i2s[addr[AW-1:0]] <= sym;
        end
        r_i2s_q <= r_i2s[i2s_ra];
    end

    always_ff @(posedge i_clk) begin
        if (key_we) begin
            r_keys[addr[KW-1:0]] <= sym;
        end
        r_key_q <= r_keys[addr[KW-1:0]];
    end

    // unmapped bytes read as index 0
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_map_vld <= '0;
            r_map_hit <= 1'b0;
        end else begin
            if (map_we) begin
                r_map_vld[sym] <= 1'b1;
            end
            r_map_hit <= r_map_vld[map_ra];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_enc       <= 1'b0;
            r_cnt       <= '0;
        end else begin
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (fire && (op inside {CMD_ENCRYPT, CMD_DECRYPT})) begin
                        r_enc   <= (op == CMD_ENCRYPT);
                        r_state <= S_KEY;
                    end
                end
                S_KEY: begin
                    r_ma    <= r_map_hit ? r_map_q : '0;
                    r_state <= S_MAP;
                end
                S_MAP: begin
                    r_ka    <= r_map_hit ? r_map_q : '0;
                    r_mr    <= '0;
                    r_kr    <= '0;
                    r_cnt   <= CNW'(AW);
                    r_state <= S_RED;
                end
                S_RED: begin
                    r_mr  <= n_mr;
                    r_kr  <= n_kr;
                    r_ma  <= r_ma << 1;
                    r_ka  <= r_ka << 1;
                    r_cnt <= r_cnt - CNW'(1);
                    if (r_cnt == CNW'(1)) begin
                        r_state <= S_SUM;
                    end
                end
                S_SUM: begin
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (out_load) begin
                        r_out_sym   <= r_i2s_q;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_out_symbol    = r_out_sym;
    assign o_status.busy   = (r_state != S_IDLE);
    assign o_status.crypt  = (r_state == S_RED);

endmodule

### rtl/vigenere_custom_alphabet.sv
// ----------------------------------------------------------------------------
// Vigenere cipher over a loadable alphabet
// Load alphabet symbols and key characters, then encrypt or decrypt bytes.
// ----------------------------------------------------------------------------
// Input channel (i_in_valid / o_in_ready) takes one word per command:
// alphabet load, key load, encrypt or decrypt. Loads give no result; each
// encrypt or decrypt word gives one o_out_symbol on the output channel
// (o_out_valid / i_out_ready). Results come out in command order.
// Config port: i_cfg_we writes i_cfg_data to the register at i_cfg_idx
// (alphabet size, key length); write only while the block is idle.
// A two-word queue parts the front end from the back end. A crypt word runs
// through registered reads of the key table, the symbol map (message, then
// key byte) and the index-to-symbol table, and the mod-n reduction at one bit
// per cycle over AW bits, AW being the alphabet index width (7 at the default
// size). Each crypt word is in the output register before the next is taken.
// If the receiver stalls, the result waits in the output register, the
// queue fills, and o_in_ready drops once it is full.
// Reset clears the queue, the output register, the key position and the
// symbol map valid bits; no clearing pass is needed.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module vigenere_custom_alphabet #(
    parameter int ALPHA_MAX = vca_pkg::ALPHA_MAX_DEF,
    parameter int KEY_MAX   = vca_pkg::KEY_MAX_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  vca_pkg::t_cfg_idx          i_cfg_idx,
    input  logic [vca_pkg::CFG_W-1:0]  i_cfg_data,
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  vca_pkg::t_cmd              i_cmd,
    input  logic [vca_pkg::POS_W-1:0]  i_position,
    input  logic [vca_pkg::SYM_W-1:0]  i_symbol,
    input  logic                       i_start_of_message,
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output logic [vca_pkg::SYM_W-1:0]  o_out_symbol
);
    import vca_pkg::*;

    localparam int EW = q_entry_w(ALPHA_MAX, KEY_MAX);
    localparam int NW = $clog2(ALPHA_MAX + 1);

    logic [ASIZE_W-1:0] r_alphabet_size;
    logic [KLEN_W-1:0]  r_key_length;
    logic [NW-1:0]      eff_n;
    logic [KLEN_W-1:0]  eff_klen;

    logic               push_valid;
    logic               push_ready;
    logic [EW-1:0]      push_data;
    logic               pop_valid;
    logic               pop_ready;
    logic [EW-1:0]      pop_data;
    t_q_status          q_st;
    t_back_status       b_st;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alphabet_size <= ASIZE_W'(ALPHA_MIN);
            r_key_length    <= KLEN_W'(1);
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_ALPHA_SIZE: r_alphabet_size <= i_cfg_data[ASIZE_W-1:0];
                CFG_KEY_LEN:    r_key_length    <= i_cfg_data[KLEN_W-1:0];
                default:        r_key_length    <= r_key_length;
            endcase
        end
    end

    always_comb begin
        if (int'(r_alphabet_size) < ALPHA_MIN) begin
            eff_n = NW'(ALPHA_MIN);
        end else if (int'(r_alphabet_size) > ALPHA_MAX) begin
            eff_n = NW'(ALPHA_MAX);
        end else begin
            eff_n = NW'(r_alphabet_size);
        end
        if (r_key_length == '0) begin
            eff_klen = KLEN_W'(1);
        end else if (int'(r_key_length) > KEY_MAX) begin
            eff_klen = KLEN_W'(KEY_MAX);
        end else begin
            eff_klen = r_key_length;
        end
    end

    vca_front #(
        .ALPHA_MAX (ALPHA_MAX),
        .KEY_MAX   (KEY_MAX)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_in_valid),
        .o_ready      (o_in_ready),
        .i_cmd        (i_cmd),
        .i_position   (i_position),
        .i_symbol     (i_symbol),
        .i_som        (i_start_of_message),
        .i_klen       (eff_klen),
        .o_push_valid (push_valid),
        .i_push_ready (push_ready),
        .o_push_data  (push_data)
    );

    vca_fifo #(
        .W (EW)
    ) u_fifo (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (push_valid),
        .o_push_ready (push_ready),
        .i_push_data  (push_data),
        .o_pop_valid  (pop_valid),
        .i_pop_ready  (pop_ready),
        .o_pop_data   (pop_data),
        .o_status     (q_st)
    );

    vca_back #(
        .ALPHA_MAX (ALPHA_MAX),
        .KEY_MAX   (KEY_MAX)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_pop_valid  (pop_valid),
        .o_pop_ready  (pop_ready),
        .i_pop_data   (pop_data),
        .i_n          (eff_n),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_out_symbol (o_out_symbol),
        .o_status     (b_st)
    );

    `VCA_ASSERT_NEVER(a_full_not_valid, i_clk, i_rst_n, q_st.full && !q_st.valid)
    `VCA_ASSERT(a_out_from_back, i_clk, i_rst_n, $rose(o_out_valid) |-> $past(b_st.busy))
    `VCA_ASSERT(a_reset_clears_out, i_clk, i_rst_n, !$past(i_rst_n) |-> !o_out_valid)
    `VCA_ASSERT_NEVER(a_reduce_idle_pop, i_clk, i_rst_n, b_st.crypt && pop_ready)

endmodule

### tb/tb_vigenere_custom_alphabet.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Vigenere custom alphabet testbench
// Loads the alphabet and key tables, then drives encrypt and decrypt words
// through the valid/ready channels under random idling and stalls. A local
// model of the tables, key position and registers predicts each output
// symbol, and results are checked in order. Registers are changed only
// while the block is idle, and the sweep includes the out-of-range values.
// ----------------------------------------------------------------------------
module tb_vigenere_custom_alphabet;
    import vca_pkg::*;

    localparam int ALPHA_MAX      = ALPHA_MAX_DEF;
    localparam int KEY_MAX        = KEY_MAX_DEF;
    localparam int SETTLE_CYCLES  = 32;
    localparam int WATCHDOG_LIMIT = 5000;

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             cfg_we = 1'b0;
    t_cfg_idx         cfg_idx = CFG_ALPHA_SIZE;
    logic [CFG_W-1:0] cfg_data = '0;
    logic             in_valid = 1'b0;
    logic             in_ready;
    t_cmd             cmd = CMD_LOAD_ALPHA;
    logic [POS_W-1:0] position = '0;
    logic [SYM_W-1:0] symbol = '0;
    logic             som = 1'b0;
    logic             out_valid;
    logic             out_ready = 1'b0;
    logic [SYM_W-1:0] out_symbol;

    // local copy of the cipher state
    logic [6:0]         sym2idx [256];
    logic [SYM_W-1:0]   idx2sym [ALPHA_MAX];
    logic [SYM_W-1:0]   key_mem [KEY_MAX];
    bit                 alpha_set [ALPHA_MAX];
    bit                 key_set [KEY_MAX];
    int                 key_pos;
    logic [ASIZE_W-1:0] asize_reg;
    logic [KLEN_W-1:0]  klen_reg;

    logic [SYM_W-1:0] pending_symbols [$];
    int               errors = 0;
    int               tx_idle_pct = 15;
    int               rx_stall_pct = 15;
    int               quiet_cycles = 0;

    vigenere_custom_alphabet dut (
        .i_clk              (clk),
        .i_rst_n            (rst_n),
        .i_cfg_we           (cfg_we),
        .i_cfg_idx          (cfg_idx),
        .i_cfg_data         (cfg_data),
        .i_in_valid         (in_valid),
        .o_in_ready         (in_ready),
        .i_cmd              (cmd),
        .i_position         (position),
        .i_symbol           (symbol),
        .i_start_of_message (som),
        .o_out_valid        (out_valid),
        .i_out_ready        (out_ready),
        .o_out_symbol       (out_symbol)
    );

    always #1 clk = ~clk;

    function automatic int alpha_n();
        if (int'(asize_reg) < ALPHA_MIN) return ALPHA_MIN;
        if (int'(asize_reg) > ALPHA_MAX) return ALPHA_MAX;
        return int'(asize_reg);
    endfunction

    function automatic int key_len();
        if (int'(klen_reg) < 1) return 1;
        if (int'(klen_reg) > KEY_MAX) return KEY_MAX;
        return int'(klen_reg);
    endfunction

    // crypt words may only read table entries that have been loaded
    function automatic bit tables_ready();
        for (int i = 0; i < alpha_n(); i++)
            if (!alpha_set[i]) return 1'b0;
        for (int i = 0; i < key_len(); i++)
            if (!key_set[i]) return 1'b0;
        return 1'b1;
    endfunction

    function automatic logic [SYM_W-1:0] pick_message();
        if ($urandom_range(99) < 80)
            return idx2sym[$urandom_range(alpha_n() - 1)];
        return SYM_W'($urandom_range(255));
    endfunction

    task automatic cipher_model(input t_cmd c, input logic [POS_W-1:0] p,
                                input logic [SYM_W-1:0] s, input logic sm);
        int n;
        int kl;
        int mi;
        int ki;
        int r;
        case (c)
            CMD_LOAD_ALPHA: begin
                if (p < ALPHA_MAX) begin
                    sym2idx[s] = p[6:0];
                    idx2sym[p] = s;
                    alpha_set[p] = 1'b1;
                end
            end
            CMD_LOAD_KEY: begin
                if (p < KEY_MAX) begin
                    key_mem[p] = s;
                    key_set[p] = 1'b1;
                end
            end
            default: begin
                n = alpha_n();
                kl = key_len();
                if (sm || key_pos >= kl) key_pos = 0;
                mi = sym2idx[s] % n;
                ki = sym2idx[key_mem[key_pos]] % n;
                if (c == CMD_ENCRYPT) r = (mi + ki) % n;
                else r = (mi + n - ki) % n;
                pending_symbols.push_back(idx2sym[r]);
                key_pos++;
                if (key_pos >= kl) key_pos = 0;
            end
        endcase
    endtask

    task automatic send_word(input t_cmd c, input logic [POS_W-1:0] p,
                             input logic [SYM_W-1:0] s, input logic sm);
        while ($urandom_range(99) < tx_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        cmd      <= c;
        position <= p;
        symbol   <= s;
        som      <= sm;
        do @(posedge clk); while (!in_ready);
        cipher_model(c, p, s, sm);
    endtask

    task automatic send_crypt(input logic sm);
        send_word($urandom_range(1) ? CMD_ENCRYPT : CMD_DECRYPT, '0, pick_message(), sm);
    endtask

    // sender holds off until every pending word has come back
    task automatic wait_results();
        in_valid <= 1'b0;
        do @(posedge clk); while (pending_symbols.size() != 0);
    endtask

    // loads leave no result, so allow the back end to finish them too
    task automatic settle();
        wait_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [CFG_W-1:0] data);
        settle();
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == CFG_ALPHA_SIZE) asize_reg = data[ASIZE_W-1:0];
        else klen_reg = data;
    endtask

    task automatic set_cipher(input logic [CFG_W-1:0] asize, input logic [CFG_W-1:0] klen);
        write_reg(CFG_ALPHA_SIZE, asize);
        write_reg(CFG_KEY_LEN, klen);
    endtask

    task automatic report_mismatch(input string what, input logic [SYM_W-1:0] got,
                                   input logic [SYM_W-1:0] want);
        $display("ERROR at %0t: %s: got %02h, want %02h", $time, what, got, want);
        errors++;
    endtask

    // result checker
    always @(posedge clk) begin
        if (rst_n && out_valid && out_ready) begin
            if (pending_symbols.size() == 0) report_mismatch("unexpected word", out_symbol, '0);
            else if (out_symbol !== pending_symbols[0])
                report_mismatch("out_symbol", out_symbol, pending_symbols.pop_front());
            else void'(pending_symbols.pop_front());
        end
    end

    always @(posedge clk) out_ready <= ($urandom_range(99) >= rx_stall_pct);

    always @(posedge clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Timeout: no word moved for %0d cycles", WATCHDOG_LIMIT);
            $display("Simulation FAILED");
            $finish;
        end
    end

    task automatic test_reset_defaults();
        // n = 2, one key character
        send_word(CMD_LOAD_ALPHA, 8'd0, 8'h41, 1'b0);
        send_word(CMD_LOAD_ALPHA, 8'd1, 8'h42, 1'b0);
        send_word(CMD_LOAD_KEY, 8'd0, 8'h42, 1'b0);
        // positions past the alphabet are dropped
        send_word(CMD_LOAD_ALPHA, 8'd128, 8'h00, 1'b0);
        send_word(CMD_LOAD_ALPHA, 8'd255, 8'hFF, 1'b0);
        send_word(CMD_ENCRYPT, 8'd0, 8'h41, 1'b1);
        send_word(CMD_ENCRYPT, 8'd0, 8'h42, 1'b0);
        send_word(CMD_DECRYPT, 8'd0, 8'h41, 1'b0);
        send_word(CMD_DECRYPT, 8'd0, 8'h42, 1'b1);
        // bytes outside the alphabet take index 0
        send_word(CMD_ENCRYPT, 8'd0, 8'h00, 1'b0);
        send_word(CMD_DECRYPT, 8'd0, 8'hFF, 1'b0);
        send_word(CMD_LOAD_KEY, 8'd255, 8'hFF, 1'b0);
        // index 127 reduced mod n
        send_word(CMD_LOAD_ALPHA, 8'd127, 8'h7E, 1'b0);
        send_word(CMD_ENCRYPT, 8'd0, 8'h7E, 1'b0);
        send_word(CMD_DECRYPT, 8'd0, 8'h7E, 1'b1);
    endtask

    task automatic test_fill_tables();
        int mul;
        int offs;
        mul  = $urandom_range(127) * 2 + 1;
        offs = $urandom_range(255);
        for (int i = 0; i < ALPHA_MAX; i++)
            send_word(CMD_LOAD_ALPHA, POS_W'(i), SYM_W'(i * mul + offs), 1'b0);
        for (int i = 0; i < KEY_MAX; i++)
            send_word(CMD_LOAD_KEY, POS_W'(i),
                      ($urandom_range(9) == 0) ? SYM_W'($urandom_range(255))
                                               : idx2sym[$urandom_range(ALPHA_MAX - 1)],
                      1'b0);
    endtask

    task automatic test_config_extremes();
        logic [CFG_W-1:0] sizes [8];
        logic [CFG_W-1:0] lens [8];
        sizes = '{9'd255, 9'd128, 9'd129, 9'd0, 9'd1, 9'd2, 9'd127, 9'd64};
        lens  = '{9'd511, 9'd256, 9'd257, 9'd0, 9'd1, 9'd1, 9'd255, 9'd3};
        for (int i = 0; i < 8; i++) begin
            set_cipher(sizes[i], lens[i]);
            for (int j = 0; j < 4; j++) send_crypt(j == 0);
        end
    endtask

    task automatic test_key_wrap_on_shrink();
        set_cipher(9'd50, 9'd200);
        for (int i = 0; i < 150; i++) send_crypt(i == 0);
        // key position now beyond the new length
        write_reg(CFG_KEY_LEN, 9'd10);
        for (int i = 0; i < 20; i++) send_crypt(1'b0);
    endtask

    task automatic test_random_traffic();
        int r;
        for (int ph = 0; ph < 6; ph++) begin
            if (ph == 0) set_cipher(CFG_W'($urandom_range(2, 12)), CFG_W'($urandom_range(1, 8)));
            else set_cipher(CFG_W'($urandom_range(255)), CFG_W'($urandom_range(511)));
            tx_idle_pct  = (ph == 3) ? 0 : 15;
            rx_stall_pct = (ph == 3) ? 0 : 15;
            for (int i = 0; i < 210; i++) begin
                if (i == 100) wait_results();
                r = $urandom_range(99);
                if (r < 75 && tables_ready()) send_crypt($urandom_range(9) == 0);
                else if (r < 88)
                    send_word(CMD_LOAD_ALPHA, POS_W'($urandom_range(255)),
                              SYM_W'($urandom_range(255)), 1'($urandom_range(1)));
                else
                    send_word(CMD_LOAD_KEY, POS_W'($urandom_range(255)),
                              SYM_W'($urandom_range(255)), 1'($urandom_range(1)));
            end
        end
        tx_idle_pct  = 15;
        rx_stall_pct = 15;
    endtask

    initial begin
        for (int i = 0; i < 256; i++) sym2idx[i] = '0;
        for (int i = 0; i < ALPHA_MAX; i++) begin
            idx2sym[i] = '0;
            alpha_set[i] = 1'b0;
        end
        for (int i = 0; i < KEY_MAX; i++) begin
            key_mem[i] = '0;
            key_set[i] = 1'b0;
        end
        key_pos   = 0;
        asize_reg = ASIZE_W'(ALPHA_MIN);
        klen_reg  = KLEN_W'(1);
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_defaults();
        test_fill_tables();
        test_config_extremes();
        test_key_wrap_on_shrink();
        test_random_traffic();
        settle();

        if (errors == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
